/* rtl/core/mccs_pkg.sv */
package mccs_pkg;

  // Command codes carried on the input tuser
  localparam logic [1:0] CMD_ARM    = 2'd0;
  localparam logic [1:0] CMD_CANCEL = 2'd1;
  localparam logic [1:0] CMD_ADV    = 2'd2;

  // Result kinds carried on the output tuser
  localparam logic KIND_FIRED   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Field widths and limits
  localparam int unsigned SLOT_W  = 3;
  localparam int unsigned TIME_W  = 31;
  localparam int unsigned DATA_W  = 72;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // Controller to datapath commands
  typedef struct packed {
    logic cap;       // latch the accepted item
    logic apply;     // arm or cancel the latched slot, restart the scan
    logic ex;        // retire the slot under scan
    logic sum;       // load the summary result
  } mccs_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic fire;      // slot under scan fires
    logic idx_last;  // scan sits on the final slot
    logic out_free;  // output register can take a result
  } mccs_stat_t;

endpackage

/* rtl/core/multi_channel_countdown_scheduler.sv */
// Channel  Dir  tdata (low bit first)                          tuser      tlast
// s_axis   in   task_slot[2:0] delay_ms[30:0] elapsed_ms[30:0]  command    -
// m_axis   out  fired_slot[2:0] fired_elapsed_ms[30:0]          kind       last
//               soonest_ms[30:0]
//
// Each item goes through these steps in order, and output stalls can hold it:
// accept, arm or cancel, a table read and a writeback for each slot, then
// the summary. The slot table has a single read and a single write port.
// Reset clears all active flags; timer values need no reset.
// A full output register holds the scan at the next firing slot.
module multi_channel_countdown_scheduler import mccs_pkg::*; #(
  parameter int unsigned TASK_COUNT = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [DATA_W-1:0] s_axis_tdata,   // task_slot, delay_ms, elapsed_ms
  input  logic [1:0]        s_axis_tuser,   // command
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [DATA_W-1:0] m_axis_tdata,   // fired_slot, fired_elapsed_ms, soonest_ms
  output logic              m_axis_tuser,   // kind
  output logic              m_axis_tlast
);

  mccs_cmd_t  cmd;
  mccs_stat_t stat;

  mccs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mccs_dp #(
    .TASK_COUNT (TASK_COUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_user_i   (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

/* rtl/core/mccs_ctrl.sv */
module mccs_ctrl import mccs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  mccs_stat_t stat_i,
  output mccs_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMD  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_EX   = 3'd3;
  localparam logic [2:0] S_SUM  = 3'd4;

  logic [2:0] state_q, state_d;

  // Sequence one item: apply, scan every slot, then summarize
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = S_CMD;
        end
      end
      S_CMD: begin
        cmd_o.apply = 1'b1;
        state_d     = S_RD;
      end
      S_RD: begin
        state_d = S_EX;
      end
      S_EX: begin
        if (!stat_i.fire || stat_i.out_free) begin
          cmd_o.ex = 1'b1;
          state_d  = stat_i.idx_last ? S_SUM : S_RD;
        end
      end
      S_SUM: begin
        if (stat_i.out_free) begin
          cmd_o.sum = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/core/mccs_dp.sv */
module mccs_dp import mccs_pkg::*; #(
  parameter int unsigned TASK_COUNT = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mccs_cmd_t         cmd_i,
  output mccs_stat_t        stat_o,
  input  logic [1:0]        in_user_i,
  input  logic [DATA_W-1:0] in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DATA_W-1:0] out_data_o,
  output logic              out_user_o,
  output logic              out_last_o
);

  localparam int unsigned IDX_W = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;

  // Latched item
  logic [1:0]        cmd_q;
  logic [SLOT_W-1:0] slot_q;
  logic [TIME_W-1:0] delay_q;
  logic [TIME_W-1:0] elapsed_q;

  // Slot table
  logic [TASK_COUNT-1:0] active_q;
  logic signed [31:0]    rem_mem [TASK_COUNT];
  logic [TIME_W-1:0]     tot_mem [TASK_COUNT];
  logic signed [31:0]    rem_rd_q;
  logic [TIME_W-1:0]     tot_rd_q;

  // Scan state
  logic [IDX_W-1:0]   idx_q;
  logic signed [31:0] min_q;

  // Output register
  logic              out_valid_q;
  logic [DATA_W-1:0] out_data_q;
  logic              out_user_q;
  logic              out_last_q;

  logic              slot_ok, arm_ok, cancel_ok, is_adv, act, upd, fire, keep;
  logic              idx_last, out_free, mem_we;
  logic [IDX_W-1:0]  slot_idx, wr_idx;
  logic [TIME_W-1:0] el_eff, new_tot, soon;
  logic [32:0]       diff;
  logic [31:0]       tot_sum;
  logic signed [31:0] new_rem, wr_rem;
  logic [TIME_W-1:0] wr_tot;

  // Latch the accepted item
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      cmd_q     <= in_user_i;
      slot_q    <= in_data_i[SLOT_W-1:0];
      delay_q   <= in_data_i[SLOT_W+TIME_W-1:SLOT_W];
      elapsed_q <= in_data_i[SLOT_W+2*TIME_W-1:SLOT_W+TIME_W];
    end
  end

  // Decode the latched command
  assign slot_ok   = {4'b0000, slot_q} < 7'(TASK_COUNT);
  assign slot_idx  = IDX_W'(slot_q);
  assign arm_ok    = (cmd_q == CMD_ARM) && slot_ok;
  assign cancel_ok = (cmd_q == CMD_CANCEL) && slot_ok;
  assign is_adv    = (cmd_q == CMD_ADV);
  assign el_eff    = is_adv ? elapsed_q : '0;

  // Count down and accumulate, both saturating
  assign diff    = {rem_rd_q[31], rem_rd_q} - {2'b00, el_eff};
  assign new_rem = (diff[32] != diff[31]) ? {1'b1, 31'd0} : diff[31:0];
  assign tot_sum = {1'b0, tot_rd_q} + {1'b0, el_eff};
  assign new_tot = tot_sum[31] ? TIME_MAX : tot_sum[TIME_W-1:0];

  assign act      = active_q[idx_q];
  assign upd      = is_adv && act;
  assign fire     = upd && (new_rem[31] || (new_rem == '0));
  assign keep     = act && !fire;
  assign idx_last = (idx_q == IDX_W'(TASK_COUNT - 1));
  assign out_free = !out_valid_q || out_ready_i;

  // Table write port: arm load or scan writeback
  assign mem_we = (cmd_i.apply && arm_ok) || (cmd_i.ex && upd);
  assign wr_idx = cmd_i.apply ? slot_idx : idx_q;
  assign wr_rem = cmd_i.apply ? $signed({1'b0, delay_q}) : new_rem;
  assign wr_tot = cmd_i.apply ? '0 : new_tot;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      rem_mem[wr_idx] <= wr_rem;
      tot_mem[wr_idx] <= wr_tot;
    end
    rem_rd_q <= rem_mem[idx_q];
    tot_rd_q <= tot_mem[idx_q];
  end

  // Active flags: set on arm, clear on cancel or fire
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else begin
      if (cmd_i.apply && arm_ok) begin
        active_q[slot_idx] <= 1'b1;
      end
      if (cmd_i.apply && cancel_ok) begin
        active_q[slot_idx] <= 1'b0;
      end
      if (cmd_i.ex && fire) begin
        active_q[idx_q] <= 1'b0;
      end
    end
  end

  // Advance the scan index and track the soonest surviving deadline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      min_q <= '0;
    end else if (cmd_i.apply) begin
      idx_q <= '0;
      min_q <= $signed({1'b0, TIME_MAX});
    end else if (cmd_i.ex) begin
      if (!idx_last) begin
        idx_q <= idx_q + 1'b1;
      end
      if (keep && (new_rem < min_q)) begin
        min_q <= new_rem;
      end
    end
  end

  assign soon = min_q[31] ? '0 : min_q[TIME_W-1:0];

  // Output register: load a fired or summary item, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((cmd_i.ex && fire) || cmd_i.sum) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ex && fire) begin
      out_data_q <= {7'd0, {TIME_W{1'b0}}, new_tot, SLOT_W'(idx_q)};
      out_user_q <= KIND_FIRED;
      out_last_q <= 1'b0;
    end else if (cmd_i.sum) begin
      out_data_q <= {7'd0, soon, {TIME_W{1'b0}}, {SLOT_W{1'b0}}};
      out_user_q <= KIND_SUMMARY;
      out_last_q <= 1'b1;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_data_q;
  assign out_user_o      = out_user_q;
  assign out_last_o      = out_last_q;
  assign stat_o.fire     = fire;
  assign stat_o.idx_last = idx_last;
  assign stat_o.out_free = out_free;

`ifndef NO_ASSERTIONS
  a_fire_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.ex && fire) |-> out_free)
    else $error("fired item loaded over a pending result");

  a_sum_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sum |-> out_free)
    else $error("summary loaded over a pending result");

  a_fire_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.ex && fire) |=> !active_q[$past(idx_q)])
    else $error("fired slot still active");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.ex && cmd_i.sum) && !(cmd_i.apply && cmd_i.ex))
    else $error("conflicting datapath commands");
`endif

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps

module testbench import mccs_pkg::*; ();

  localparam int unsigned TASKS      = 8;
  localparam int unsigned DIR_N      = 24;
  localparam int unsigned RAND_N     = 510;
  localparam int unsigned TAIL_WAIT  = 60;
  localparam logic [1:0]  CMD_UNUSED = 2'd3;

  // One result item as it leaves the block
  typedef struct packed {
    logic              kind;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] fired_el;
    logic [TIME_W-1:0] soon;
    logic              last;
  } sched_res_t;

  // One directed command, with a typed summary where it is obvious
  typedef struct packed {
    logic [1:0]        cmd;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] dly;
    logic [TIME_W-1:0] el;
    logic              typed;
    logic [TIME_W-1:0] soon;
  } stim_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata = '0;   // task_slot, delay_ms, elapsed_ms
  logic [1:0]        s_axis_tuser = '0;   // command
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [DATA_W-1:0] m_axis_tdata;        // fired_slot, fired_elapsed_ms, soonest_ms
  logic              m_axis_tuser;        // kind
  logic              m_axis_tlast;

  multi_channel_countdown_scheduler #(
    .TASK_COUNT(TASKS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // Timer table copy used for prediction
  bit                       act_tab [TASKS];
  logic signed [31:0]       rem_tab [TASKS];
  logic        [TIME_W-1:0] tot_tab [TASKS];

  sched_res_t due_q [$];
  stim_row_t  dir_tab [DIR_N];

  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned err_cnt = 0;
  int unsigned n_arm = 0, n_cancel = 0, n_adv = 0, n_unused = 0;
  int unsigned n_fired = 0, n_summ = 0, max_burst = 0;

  // Clock: 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Hard limit on run length
  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

  // Apply one command to the timer table; queue its results when asked
  task automatic step_timers(input logic [1:0] cmd, input logic [SLOT_W-1:0] slot,
                             input logic [TIME_W-1:0] dly, input logic [TIME_W-1:0] el,
                             input bit keep);
    longint      rem;
    longint      tot;
    longint      soon;
    int unsigned burst;
    sched_res_t  r;
    soon  = longint'(TIME_MAX);
    burst = 0;
    case (cmd)
      CMD_ARM: begin
        n_arm++;
        if (slot < TASKS) begin
          act_tab[slot] = 1'b1;
          rem_tab[slot] = $signed({1'b0, dly});
          tot_tab[slot] = '0;
        end
      end
      CMD_CANCEL: begin
        n_cancel++;
        if (slot < TASKS) act_tab[slot] = 1'b0;
      end
      CMD_ADV: begin
        n_adv++;
        // count down and accumulate, both saturating
        for (int i = 0; i < TASKS; i++) begin
          if (act_tab[i]) begin
            rem = longint'(rem_tab[i]) - longint'(el);
            if (rem < -64'sd2147483648) rem = -64'sd2147483648;
            rem_tab[i] = rem[31:0];
            tot = longint'(tot_tab[i]) + longint'(el);
            if (tot > longint'(TIME_MAX)) tot = longint'(TIME_MAX);
            tot_tab[i] = tot[TIME_W-1:0];
          end
        end
        // retire expired slots in index order
        for (int i = 0; i < TASKS; i++) begin
          if (act_tab[i] && rem_tab[i] <= 0) begin
            act_tab[i] = 1'b0;
            r.kind     = KIND_FIRED;
            r.slot     = SLOT_W'(i);
            r.fired_el = tot_tab[i];
            r.soon     = '0;
            r.last     = 1'b0;
            if (keep) due_q.push_back(r);
            burst++;
          end
        end
      end
      default: n_unused++;
    endcase
    n_fired += burst;
    if (burst > max_burst) max_burst = burst;
    // soonest deadline among what is still active
    for (int i = 0; i < TASKS; i++) begin
      if (act_tab[i] && longint'(rem_tab[i]) < soon) soon = longint'(rem_tab[i]);
    end
    if (soon < 0) soon = 0;
    r.kind     = KIND_SUMMARY;
    r.slot     = '0;
    r.fired_el = '0;
    r.soon     = soon[TIME_W-1:0];
    r.last     = 1'b1;
    if (keep) due_q.push_back(r);
    n_summ++;
  endtask

  // Offer one command, hold it until accepted; called at a falling edge
  task automatic send_item(input logic [1:0] cmd, input logic [SLOT_W-1:0] slot,
                           input logic [TIME_W-1:0] dly, input logic [TIME_W-1:0] el,
                           input bit typed, input logic [TIME_W-1:0] soon);
    sched_res_t r;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {{(DATA_W - SLOT_W - 2 * TIME_W){1'b0}}, el, dly, slot};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    step_timers(cmd, slot, dly, el, !typed);
    if (typed) begin
      r.kind     = KIND_SUMMARY;
      r.slot     = '0;
      r.fired_el = '0;
      r.soon     = soon;
      r.last     = 1'b1;
      due_q.push_back(r);
    end
    @(negedge clk_i);
  endtask

  // Hold the sender until every queued result has come out
  task automatic drain_results();
    if (due_q.size() != 0) begin
      s_axis_tvalid <= 1'b0;
      while (due_q.size() != 0) @(negedge clk_i);
    end
  endtask

  // Random command, mostly arm and advance with moderate times
  task automatic send_random();
    logic [1:0]        cmd;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] dly;
    logic [TIME_W-1:0] el;
    int unsigned       pick;
    pick = $urandom_range(99);
    if (pick < 45)      cmd = CMD_ARM;
    else if (pick < 60) cmd = CMD_CANCEL;
    else if (pick < 95) cmd = CMD_ADV;
    else                cmd = CMD_UNUSED;
    slot = SLOT_W'($urandom_range(TASKS - 1));
    case ($urandom_range(9))
      0:       dly = '0;
      1:       dly = TIME_MAX;
      2, 3:    dly = TIME_W'($urandom);
      default: dly = TIME_W'($urandom_range(2000, 1));
    endcase
    case ($urandom_range(19))
      0:       el = '0;
      1:       el = TIME_MAX;
      2, 3:    el = TIME_W'($urandom);
      default: el = TIME_W'($urandom_range(800));
    endcase
    send_item(cmd, slot, dly, el, 1'b0, '0);
  endtask

  // Receiver back-pressure
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    sched_res_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (due_q.size() == 0) begin
        $error("unexpected result: kind %0d tdata %h", m_axis_tuser, m_axis_tdata);
        err_cnt++;
      end else begin
        e = due_q.pop_front();
        if (m_axis_tuser !== e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, m_axis_tuser);
          err_cnt++;
        end
        if (m_axis_tdata[SLOT_W-1:0] !== e.slot) begin
          $error("fired_slot: expected %0d, got %0d", e.slot, m_axis_tdata[SLOT_W-1:0]);
          err_cnt++;
        end
        if (m_axis_tdata[SLOT_W +: TIME_W] !== e.fired_el) begin
          $error("fired_elapsed_ms: expected %0d, got %0d", e.fired_el,
                 m_axis_tdata[SLOT_W +: TIME_W]);
          err_cnt++;
        end
        if (m_axis_tdata[SLOT_W + TIME_W +: TIME_W] !== e.soon) begin
          $error("soonest_ms: expected %0d, got %0d", e.soon,
                 m_axis_tdata[SLOT_W + TIME_W +: TIME_W]);
          err_cnt++;
        end
        if (m_axis_tlast !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, m_axis_tlast);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < TASKS; i++) begin
      act_tab[i] = 1'b0;
      rem_tab[i] = '0;
      tot_tab[i] = '0;
    end

    // cmd, slot, delay, elapsed, typed, soonest
    dir_tab = '{
      '{CMD_ADV,    3'd0, 31'd0,    31'd0,          1'b1, TIME_MAX},
      '{CMD_UNUSED, 3'd7, TIME_MAX, TIME_MAX,       1'b1, TIME_MAX},
      '{CMD_CANCEL, 3'd5, 31'd0,    31'd0,          1'b1, TIME_MAX},
      '{CMD_ARM,    3'd0, TIME_MAX, 31'd0,          1'b1, TIME_MAX},
      '{CMD_ARM,    3'd7, 31'd0,    31'd0,          1'b1, 31'd0},
      '{CMD_ADV,    3'd0, 31'd0,    31'd0,          1'b0, 31'd0},
      '{CMD_ARM,    3'd3, 31'd1,    31'd0,          1'b1, 31'd1},
      '{CMD_ADV,    3'd0, 31'd0,    TIME_MAX,       1'b0, 31'd0},
      '{CMD_ARM,    3'd5, TIME_MAX, 31'd0,          1'b1, TIME_MAX},
      '{CMD_ADV,    3'd0, 31'd0,    TIME_MAX - 31'd1, 1'b0, 31'd0},
      '{CMD_ADV,    3'd0, 31'd0,    TIME_MAX,       1'b0, 31'd0},
      '{CMD_ARM,    3'd1, 31'd100,  31'd0,          1'b1, 31'd100},
      '{CMD_ARM,    3'd2, 31'd50,   31'd0,          1'b1, 31'd50},
      '{CMD_ADV,    3'd0, 31'd0,    31'd30,         1'b0, 31'd0},
      '{CMD_CANCEL, 3'd2, 31'd0,    31'd0,          1'b0, 31'd0},
      '{CMD_ARM,    3'd0, 31'd1,    31'd0,          1'b0, 31'd0},
      '{CMD_ARM,    3'd1, 31'd2,    31'd0,          1'b0, 31'd0},
      '{CMD_ARM,    3'd2, 31'd3,    31'd0,          1'b0, 31'd0},
      '{CMD_ARM,    3'd3, 31'd4,    31'd0,          1'b0, 31'd0},
      '{CMD_ARM,    3'd4, 31'd5,    31'd0,          1'b0, 31'd0},
      '{CMD_ARM,    3'd5, 31'd6,    31'd0,          1'b0, 31'd0},
      '{CMD_ARM,    3'd6, 31'd7,    31'd0,          1'b0, 31'd0},
      '{CMD_ARM,    3'd7, 31'd8,    31'd0,          1'b0, 31'd0},
      '{CMD_ADV,    3'd0, 31'd0,    31'd8,          1'b0, 31'd0}
    };

    // Hold reset, then release it at a falling edge
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Phase one: light sender idling, heavy receiver stalls
    src_idle_pct  = 6;
    snk_stall_pct = 51;
    foreach (dir_tab[i]) begin
      send_item(dir_tab[i].cmd, dir_tab[i].slot, dir_tab[i].dly, dir_tab[i].el,
                dir_tab[i].typed, dir_tab[i].soon);
    end

    for (int ph = 0; ph < 3; ph++) begin
      drain_results();
      src_idle_pct  = (ph == 0) ? 6 : (ph == 1) ? 51 : 0;
      snk_stall_pct = (ph == 0) ? 51 : (ph == 1) ? 6 : 0;
      for (int n = 0; n < RAND_N / 3; n++) begin
        if ($urandom_range(49) == 0) drain_results();
        send_random();
      end
    end

    // Wait out every expected result, then a quiet tail
    s_axis_tvalid <= 1'b0;
    while (due_q.size() != 0) @(negedge clk_i);
    repeat (TAIL_WAIT) @(negedge clk_i);

    $display("Commands: %0d arm, %0d cancel, %0d advance, %0d unknown", n_arm, n_cancel,
             n_adv, n_unused);
    $display("Results: %0d fired, %0d summaries, up to %0d fired per advance", n_fired,
             n_summ, max_burst);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/mccs_pkg.sv
rtl/core/mccs_ctrl.sv
rtl/core/mccs_dp.sv
rtl/core/multi_channel_countdown_scheduler.sv
verif/testbench.sv
